### sv/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

  localparam int WORD_W      = 32;  // bitmap bits held by one cell
  localparam int WORD_IDX_W  = 5;   // bit index inside a cell word
  localparam int BLK_W       = 10;  // block number width
  localparam int LIM_W       = 11;  // partition limit width
  localparam int FIELD_REACH = 1024;

  localparam logic [LIM_W-1:0] FIRST_USABLE = 11'd2;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Request token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             req;
    logic [BLK_W-1:0] blk;
    logic             ok;
    logic [BLK_W-1:0] granted;
  } token_t;

endpackage

### sv/bba_cell.sv
// One cell of the allocator chain: holds 32 bitmap bits and serves a passing request.
module bba_cell import bba_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LIM_W-1:0] lim,
  input  token_t           tok_in,
  output token_t           tok_out
);

  localparam logic [LIM_W-1:0] BASE = LIM_W'(CELL_IDX * WORD_W);

  logic [WORD_W-1:0]     word;
  logic [WORD_W-1:0]     word_next;
  token_t                tok_next;
  logic [WORD_W-1:0]     cand;
  logic [WORD_IDX_W-1:0] pick;
  logic                  any;
  logic [LIM_W-1:0]      blk_ext;
  logic                  hit;

  // Free candidates in this word: free, not reserved, below the limit
  always_comb begin
    logic [LIM_W-1:0] g;
    g = '0;
    for (int j = 0; j < WORD_W; j++) begin
      g = BASE + LIM_W'(j);
      cand[j] = !word[j] && (g >= FIRST_USABLE) && (g < lim);
    end
  end

  // Lowest candidate wins
  always_comb begin
    any  = 1'b0;
    pick = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        any  = 1'b1;
        pick = WORD_IDX_W'(j);
      end
    end
  end

  // Free check for a block that lives in this cell
  assign blk_ext = {1'b0, tok_in.blk};
  assign hit = (tok_in.blk[BLK_W-1:WORD_IDX_W] == (BLK_W - WORD_IDX_W)'(CELL_IDX)) &&
               (blk_ext >= FIRST_USABLE) && (blk_ext < lim) &&
               word[tok_in.blk[WORD_IDX_W-1:0]];

  // Request handling
  always_comb begin
    tok_next  = tok_in;
    word_next = word;
    if (tok_in.valid) begin
      if (tok_in.req == REQ_ALLOC) begin
        if (!tok_in.ok && any) begin
          word_next[pick]  = 1'b1;
          tok_next.ok      = 1'b1;
          tok_next.granted = BLK_W'(BASE + LIM_W'(pick));
        end
      end else if (tok_in.req == REQ_FREE) begin
        if (hit) begin
          word_next[tok_in.blk[WORD_IDX_W-1:0]] = 1'b0;
          tok_next.ok = 1'b1;
        end
      end
    end
  end

  // Bitmap word and token register
  always_ff @(posedge clk) begin
    if (rst) begin
      word    <= '0;
      tok_out <= '0;
    end else begin
      word    <= word_next;
      tok_out <= tok_next;
    end
  end

endmodule

### sv/bitmap_block_allocator.sv
// A request walks the cell chain, one cell per cycle, then two register stages: payload register and output register.
// The cell chain holds only one request at a time.
// The next request is taken once the previous result sits in the output register, even if not yet taken.
// Reset (rst, synchronous) clears the whole bitmap and sets partition_size to 1024.
// Top level of the first-fit bitmap block allocator.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [LIM_W-1:0] cfg_wr_data,   // partition_size
  // request channel
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [15:0]      s_tdata,       // [9:0] block_number, [15:10] zero
  input  logic             s_tuser,       // [0] req_type
  // result channel
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,       // [9:0] granted_block, [15:10] zero
  output logic             m_tuser        // [0] ok
);

  localparam int CAP       = (NUM_BLOCKS < FIELD_REACH) ? NUM_BLOCKS : FIELD_REACH;
  localparam int NUM_CELLS = (CAP + WORD_W - 1) / WORD_W;
  localparam logic [LIM_W-1:0] CAP_L = LIM_W'(CAP);

  logic [LIM_W-1:0] partition_size;
  logic [LIM_W-1:0] lim;
  logic             busy;
  logic             pend;
  logic             res_ok;
  logic [BLK_W-1:0] res_granted;
  logic             in_acc;
  logic             out_free;
  token_t           tok [NUM_CELLS + 1];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      partition_size <= 11'd1024;
    end else if (cfg_wr_en) begin
      partition_size <= cfg_wr_data;
    end
  end

  assign lim = (partition_size > CAP_L) ? CAP_L : partition_size;

  // Request injection into the chain
  assign s_tready = !busy;
  assign in_acc   = s_tvalid && s_tready;

  always_comb begin
    tok[0]         = '0;
    tok[0].valid   = in_acc;
    tok[0].req     = s_tuser;
    tok[0].blk     = s_tdata[BLK_W-1:0];
  end

  // Cell chain
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    bba_cell #(.CELL_IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .lim     (lim),
      .tok_in  (tok[i]),
      .tok_out (tok[i + 1])
    );
  end

  assign out_free = !m_tvalid || m_tready;

  // Result holding and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end
      if (tok[NUM_CELLS].valid) begin
        pend <= 1'b1;
      end
      if (pend && out_free) begin
        pend     <= 1'b0;
        busy     <= 1'b0;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (tok[NUM_CELLS].valid) begin
      res_ok      <= tok[NUM_CELLS].ok;
      res_granted <= tok[NUM_CELLS].granted;
    end
    if (pend && out_free) begin
      m_tuser <= res_ok;
      m_tdata <= {6'b0, res_granted};
    end
  end

endmodule

### bench/tb.sv
// Testbench for the first-fit bitmap block allocator: bitmap tracker, directed and random requests.
module tb;
  import bba_pkg::*;

  localparam int N_BLOCKS  = 1024;
  localparam int DRAIN_CYC = 40;       // drain wait after every owed grant is back
  localparam int WAIT_CAP  = 100000;   // cap on any wait for outstanding grants

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [LIM_W-1:0] cfg_wr_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata = '0;    // [9:0] block_number, [15:10] zero
  logic             s_tuser = 1'b0;  // [0] req_type
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;         // [9:0] granted_block, [15:10] zero
  logic             m_tuser;         // [0] ok

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  typedef struct packed {
    logic             ok;
    logic [BLK_W-1:0] granted;
  } grant_t;

  // Tracks the used/free bitmap and the grants still owed by the block
  class block_map_model;
    bit [N_BLOCKS-1:0] used_map;
    logic [LIM_W-1:0]  part_size;
    grant_t            grants_due[$];
    int                errors;

    function new();
      used_map  = '0;
      part_size = 11'd1024;
      errors    = 0;
    endfunction

    function void set_partition(logic [LIM_W-1:0] size);
      part_size = size;
    endfunction

    // Usable blocks lie below this bound
    function int limit();
      int lim;
      lim = part_size;
      if (lim > N_BLOCKS) lim = N_BLOCKS;
      if (lim > FIELD_REACH) lim = FIELD_REACH;
      return lim;
    endfunction

    function int outstanding();
      return grants_due.size();
    endfunction

    // Apply an accepted request to the bitmap and queue its grant
    function void take_request(logic req, logic [BLK_W-1:0] blk);
      grant_t g;
      int lim;
      g   = '0;
      lim = limit();
      if (req == REQ_ALLOC) begin
        for (int i = FIRST_USABLE; i < lim; i++) begin
          if (!used_map[i]) begin
            used_map[i] = 1'b1;
            g.ok        = 1'b1;
            g.granted   = i[BLK_W-1:0];
            break;
          end
        end
      end else if (blk >= FIRST_USABLE && blk < lim && used_map[blk]) begin
        used_map[blk] = 1'b0;
        g.ok          = 1'b1;
      end
      grants_due.push_back(g);
    endfunction

    function void match_grant(logic ok, logic [BLK_W-1:0] granted);
      grant_t g;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected grant ok=%0d block=%0d", $time, ok, granted);
        errors++;
        return;
      end
      g = grants_due.pop_front();
      if (ok !== g.ok) begin
        $display("%0t: ok expected %0d got %0d", $time, g.ok, ok);
        errors++;
      end
      if (granted !== g.granted) begin
        $display("%0t: granted_block expected %0d got %0d", $time, g.granted, granted);
        errors++;
      end
    endfunction

    // A random block currently marked used inside the partition, or -1
    function int pick_used();
      int lim, span, start, b;
      lim = limit();
      if (lim <= FIRST_USABLE) return -1;
      span  = lim - FIRST_USABLE;
      start = $urandom_range(span - 1);
      for (int k = 0; k < span; k++) begin
        b = FIRST_USABLE + (start + k) % span;
        if (used_map[b]) return b;
      end
      return -1;
    endfunction
  endclass

  block_map_model bitmap = new();

  bitmap_block_allocator #(.NUM_BLOCKS(N_BLOCKS)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both buses are stable at the falling edge; a handshake seen here completes at the next rise
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) bitmap.take_request(s_tuser, s_tdata[BLK_W-1:0]);
      if (m_tvalid && m_tready) bitmap.match_grant(m_tuser, m_tdata[BLK_W-1:0]);
    end
  end

  // Present one request and hold it until accepted; returns at the accepting edge
  task automatic send_request(logic req, logic [BLK_W-1:0] blk);
    int gap;
    logic taken;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, blk};
    s_tuser  <= req;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stop sending and let every owed grant come back
  task automatic wait_idle();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (bitmap.outstanding() > 0 && n < WAIT_CAP) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_partition(logic [LIM_W-1:0] size);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bitmap.set_partition(size);
  endtask

  // Mostly allocates and frees of live blocks; the rest frees a reserved block or is arbitrary
  task automatic random_request();
    int r, b;
    r = $urandom_range(99);
    if (r < 55) begin
      send_request(REQ_ALLOC, BLK_W'($urandom_range(1023)));
    end else if (r < 88) begin
      b = bitmap.pick_used();
      if (b < 0) send_request(REQ_ALLOC, BLK_W'($urandom_range(1023)));
      else       send_request(REQ_FREE, b[BLK_W-1:0]);
    end else if (r < 92) begin
      send_request(REQ_FREE, BLK_W'($urandom_range(1)));
    end else begin
      send_request(1'($urandom_range(1)), BLK_W'($urandom_range(1023)));
    end
  endtask

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [LIM_W-1:0] sizes [12];
    sizes = '{11'd1024, 11'd24, 11'd2047, 11'd6, 11'd70, 11'd0,
              11'd300, 11'd3, 11'd40, 11'd1, 11'd2, 11'd1024};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reserved blocks, double free, lowest-first reuse, partition edges
    send_request(REQ_FREE, 10'd0);
    send_request(REQ_FREE, 10'd1);
    send_request(REQ_FREE, 10'd1023);
    send_request(REQ_FREE, 10'd2);
    send_request(REQ_ALLOC, 10'd1023);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_ALLOC, 10'd555);
    send_request(REQ_FREE, 10'd3);
    send_request(REQ_FREE, 10'd3);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_FREE, 10'd4);
    write_partition(11'd3);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_FREE, 10'd2);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_FREE, 10'd5);
    write_partition(11'd0);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_FREE, 10'd2);
    write_partition(11'd2);
    send_request(REQ_ALLOC, 10'd0);
    write_partition(11'd2047);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_FREE, 10'd1023);
    send_request(REQ_FREE, 10'd3);

    // Random phases, each with a partition size from the list and one of four idle patterns
    for (int p = 0; p < 12; p++) begin
      write_partition(sizes[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int k = 0; k < 146; k++) begin
        random_request();
        if ($urandom_range(199) == 0) wait_idle();
      end
    end

    wait_idle();
    if (bitmap.errors == 0 && bitmap.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
